@@ rtl/core/ard_pkg.sv @@
package ard_pkg;

    localparam int QUEUE_DEPTH      = 8;
    localparam int USER_TABLE_DEPTH = 256;
    localparam int AXES             = 6;

    localparam logic [7:0] ACK_CODE_RESET = 8'h06;
    localparam logic [7:0] SYNC_BYTE      = 8'h52;

    typedef enum logic [1:0] {
        CMD_RX    = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_START = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        EV_WRITE    = 3'd0,
        EV_ACK      = 3'd1,
        EV_NAK      = 3'd2,
        EV_RESYNC   = 3'd3,
        EV_BADKIND  = 3'd4,
        EV_OVERFLOW = 3'd5
    } t_event;

    localparam logic [2:0] FT_RS = 3'd4;
    localparam logic [2:0] FT_RG = 3'd5;

    // one classified transaction from front to back
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [2:0] req_kind;
        logic [1:0] actuator;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  frame_type;
        logic [2:0]  table_res;
        logic [7:0]  entry_index;
        logic [31:0] entry_value;
        logic [1:0]  busy_mask;
    } t_result;

endpackage

@@ rtl/core/actuator_response_deframer_top.sv @@
// Deframes actuator controller replies and tracks busy actuators. Each
// transaction (byte, read notice, stop notice, move start) is one queue
// entry; a two-entry input queue decouples the push side from the parser,
// which takes one transaction per cycle unless its result queue of
// QUEUE_DEPTH entries is full. Input stalls when the input queue is full.
module actuator_response_deframer_top #(
    parameter int QUEUE_DEPTH      = ard_pkg::QUEUE_DEPTH,
    parameter int USER_TABLE_DEPTH = ard_pkg::USER_TABLE_DEPTH,
    parameter int AXES             = ard_pkg::AXES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic [2:0]  i_req_kind,
    input  logic [1:0]  i_actuator,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_res,
    output logic [2:0]  o_frame_type,
    output logic [2:0]  o_table_res,
    output logic [7:0]  o_entry_index,
    output logic signed [31:0] o_entry_value,
    output logic [1:0]  o_busy_mask
);
    logic [7:0]       r_ack_code;
    ard_pkg::t_item   in_item, q_item;
    ard_pkg::t_result res, q_res;
    logic             q_empty, take, res_push, res_full;

    // ack code register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ack_code <= ard_pkg::ACK_CODE_RESET;
        else if (i_cfg_we) r_ack_code <= i_cfg_wdata;
    end

    assign in_item = '{cmd: i_cmd, rx_byte: i_rx_byte,
                       req_kind: i_req_kind, actuator: i_actuator};

    // front queue
    ard_fifo #(.WIDTH($bits(ard_pkg::t_item)), .DEPTH(2)) u_in (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(in_item),
        .o_full(full), .i_pop(take), .o_empty(q_empty), .o_data(q_item));

    // parser
    ard_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .USER_TABLE_DEPTH(USER_TABLE_DEPTH),
               .AXES(AXES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ack_code(r_ack_code),
        .i_valid(!q_empty), .i_item(q_item), .o_take(take),
        .o_res_push(res_push), .o_res(res), .i_res_full(res_full));

    // result queue
    ard_fifo #(.WIDTH($bits(ard_pkg::t_result)), .DEPTH(QUEUE_DEPTH)) u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_push), .i_data(res),
        .o_full(res_full), .i_pop(pop), .o_empty(empty), .o_data(q_res));

    assign o_event_res   = q_res.event_res;
    assign o_frame_type  = q_res.frame_type;
    assign o_table_res   = q_res.table_res;
    assign o_entry_index = q_res.entry_index;
    assign o_entry_value = q_res.entry_value;
    assign o_busy_mask   = q_res.busy_mask;

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> !q_empty) else $error("take from empty queue");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full) else $error("result push while full");
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> $stable(r_ack_code)) else $error("ack code changed");
endmodule

@@ rtl/core/ard_fifo.sv @@
module ard_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !(r_cnt > (AW+1)'(DEPTH))) else $error("fifo overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !i_push) |=> o_empty) else $error("fifo underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> !o_empty) else $error("fifo count");
endmodule

@@ rtl/core/ard_back.sv @@
module ard_back #(
    parameter int QUEUE_DEPTH      = ard_pkg::QUEUE_DEPTH,
    parameter int USER_TABLE_DEPTH = ard_pkg::USER_TABLE_DEPTH,
    parameter int AXES             = ard_pkg::AXES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_ack_code,
    input  logic             i_valid,
    input  ard_pkg::t_item   i_item,
    output logic             o_take,
    output logic             o_res_push,
    output ard_pkg::t_result o_res,
    input  logic             i_res_full
);
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [2:0] {
        PH_HUNT, PH_START, PH_LETTER, PH_HEADER, PH_DISCARD, PH_PAYLOAD, PH_CRC
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hc, n_hc;
    logic [2:0]  r_type, n_type;
    logic        r_ok, n_ok;
    logic [15:0] r_len, n_len;
    logic [15:0] r_pc, n_pc;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_busy, n_busy;
    logic [2:0]  r_kq [QUEUE_DEPTH];
    logic [1:0]  r_sq [QUEUE_DEPTH];
    logic [QA-1:0] r_kh, r_kt, r_sh, r_st;
    logic [QW-1:0] r_kc, r_sc;
    logic        kpush, kpop, spush, spop;
    logic        emit;
    ard_pkg::t_result res;

    // a result needs room, so stall while the output queue is full
    assign o_take     = i_valid && !i_res_full;
    assign o_res_push = o_take && emit;
    assign o_res      = res;

    // frame parser and table decoder
    always_comb begin
        logic [2:0]  kind;
        logic [2:0]  wsize;
        logic [1:0]  lane;
        logic [15:0] w, depth;
        logic [7:0]  b;
        n_phase = r_phase; n_hc = r_hc; n_type = r_type; n_ok = r_ok;
        n_len = r_len; n_pc = r_pc; n_acc = r_acc; n_busy = r_busy;
        kpush = 1'b0; kpop = 1'b0; spush = 1'b0; spop = 1'b0;
        emit = 1'b0;
        res = '0;
        b = i_item.rx_byte;
        kind = (r_kc != '0) ? r_kq[r_kh] : 3'd0;
        wsize = 3'd0;
        depth = 16'(AXES);
        lane = 2'd0;
        w = 16'd0;
        case (i_item.cmd)
            ard_pkg::CMD_RX: begin
                case (r_phase)
                    PH_HUNT: begin
                        if (b == ard_pkg::SYNC_BYTE) n_phase = PH_LETTER;
                    end
                    PH_START: begin
                        if (b == ard_pkg::SYNC_BYTE) begin
                            n_phase = PH_LETTER;
                        end else begin
                            n_phase = PH_DISCARD; n_hc = 3'd1;
                            emit = 1'b1; res.event_res = ard_pkg::EV_RESYNC;
                        end
                    end
                    PH_LETTER: begin
                        n_hc = 3'd2; n_phase = PH_HEADER;
                        case (b)
                            8'h4F: n_type = 3'd0;
                            8'h43: n_type = 3'd1;
                            8'h54: n_type = 3'd2;
                            8'h45: n_type = 3'd3;
                            8'h53: n_type = 3'd4;
                            8'h47: n_type = 3'd5;
                            default: begin
                                n_phase = PH_DISCARD;
                                emit = 1'b1; res.event_res = ard_pkg::EV_RESYNC;
                            end
                        endcase
                    end
                    PH_DISCARD: begin
                        n_hc = r_hc + 3'd1;
                        if (n_hc >= 3'd4) n_phase = PH_HUNT;
                    end
                    PH_HEADER: begin
                        if (r_hc == 3'd2) begin
                            n_ok = (b == i_ack_code); n_hc = 3'd3;
                        end else if (r_hc == 3'd3) begin
                            n_len = {8'd0, b}; n_hc = 3'd4;
                        end else if (r_type == ard_pkg::FT_RG && r_ok) begin
                            n_len = {b, r_len[7:0]};
                            n_pc = '0; n_acc = '0; n_hc = 3'd0;
                            n_phase = (n_len != '0) ? PH_PAYLOAD : PH_CRC;
                        end else begin
                            n_phase = PH_START;
                            if (r_type == ard_pkg::FT_RS && r_sc != '0) begin
                                if (r_ok && r_sq[r_sh] == 2'd1) n_busy[0] = 1'b0;
                                if (r_ok && r_sq[r_sh] == 2'd2) n_busy[1] = 1'b0;
                                spop = 1'b1;
                            end
                            emit = 1'b1;
                            res.event_res = r_ok ? ard_pkg::EV_ACK : ard_pkg::EV_NAK;
                            res.frame_type = r_type;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_pc = r_pc + 16'd1;
                        if (n_pc == r_len) begin
                            n_phase = PH_CRC; n_hc = 3'd0;
                        end
                        case (kind)
                            3'd1: begin wsize = 3'd4; depth = 16'(USER_TABLE_DEPTH); end
                            3'd2, 3'd4: wsize = 3'd4;
                            3'd3, 3'd6: wsize = 3'd2;
                            3'd5: wsize = 3'd1;
                            default: wsize = 3'd0;
                        endcase
                        if (wsize != 3'd0) begin
                            lane = (wsize == 3'd4) ? r_pc[1:0] :
                                   (wsize == 3'd2) ? {1'b0, r_pc[0]} : 2'd0;
                            w = (wsize == 3'd4) ? {2'd0, r_pc[15:2]} :
                                (wsize == 3'd2) ? {1'b0, r_pc[15:1]} : r_pc;
                            if (lane == 2'd0) n_acc = {24'd0, b};
                            else n_acc = r_acc | ({24'd0, b} << {lane, 3'd0});
                            if (lane == 2'(wsize - 3'd1) && w < depth) begin
                                emit = 1'b1;
                                res.event_res = ard_pkg::EV_WRITE;
                                res.frame_type = ard_pkg::FT_RG;
                                res.table_res = kind - 3'd1;
                                res.entry_index = w[7:0];
                                res.entry_value = (kind == 3'd5) ? {31'd0, b[4]} :
                                    (wsize == 3'd2) ? {16'd0, n_acc[15:0]} : n_acc;
                            end
                        end
                    end
                    PH_CRC: begin
                        n_hc = r_hc + 3'd1;
                        if (n_hc >= 3'd2) begin
                            kpop = (r_kc != '0);
                            n_phase = PH_START;
                            emit = 1'b1;
                            res.event_res = (r_kc != '0 && kind >= 3'd1 && kind <= 3'd6)
                                ? ard_pkg::EV_ACK : ard_pkg::EV_BADKIND;
                            res.frame_type = ard_pkg::FT_RG;
                        end
                    end
                    default: n_phase = PH_HUNT;
                endcase
            end
            ard_pkg::CMD_READ: begin
                if (r_kc == QW'(QUEUE_DEPTH)) begin
                    emit = 1'b1; res.event_res = ard_pkg::EV_OVERFLOW;
                    res.frame_type = ard_pkg::FT_RG;
                end else kpush = 1'b1;
            end
            ard_pkg::CMD_STOP: begin
                if (r_sc == QW'(QUEUE_DEPTH)) begin
                    emit = 1'b1; res.event_res = ard_pkg::EV_OVERFLOW;
                    res.frame_type = ard_pkg::FT_RS;
                end else spush = 1'b1;
            end
            default: begin
                if (i_item.actuator == 2'd1) n_busy[0] = 1'b1;
                if (i_item.actuator == 2'd2) n_busy[1] = 1'b1;
            end
        endcase
        res.busy_mask = n_busy;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (o_take && kpush) r_kq[r_kt] <= i_item.req_kind;
        if (o_take && spush) r_sq[r_st] <= i_item.actuator;
    end

    // parser state and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT; r_hc <= '0; r_type <= '0; r_ok <= 1'b0;
            r_len <= '0; r_pc <= '0; r_acc <= '0; r_busy <= '0;
            r_kh <= '0; r_kt <= '0; r_kc <= '0;
            r_sh <= '0; r_st <= '0; r_sc <= '0;
        end else if (o_take) begin
            r_phase <= n_phase; r_hc <= n_hc; r_type <= n_type; r_ok <= n_ok;
            r_len <= n_len; r_pc <= n_pc; r_acc <= n_acc; r_busy <= n_busy;
            if (kpush) r_kt <= (r_kt == QA'(QUEUE_DEPTH-1)) ? '0 : r_kt + 1'b1;
            if (kpop)  r_kh <= (r_kh == QA'(QUEUE_DEPTH-1)) ? '0 : r_kh + 1'b1;
            if (spush) r_st <= (r_st == QA'(QUEUE_DEPTH-1)) ? '0 : r_st + 1'b1;
            if (spop)  r_sh <= (r_sh == QA'(QUEUE_DEPTH-1)) ? '0 : r_sh + 1'b1;
            r_kc <= r_kc + QW'(kpush) - QW'(kpop);
            r_sc <= r_sc + QW'(spush) - QW'(spop);
        end
    end

    a_kq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_kc > QW'(QUEUE_DEPTH))) else $error("kind queue count");
    a_sq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sc > QW'(QUEUE_DEPTH))) else $error("stop queue count");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full) else $error("result lost");
endmodule
